### src/deq_pkg.sv
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_BACK  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} deq_cmd_t;

endpackage

`default_nettype wire

### src/deq_ctrl.sv
// controller state machine: sequences capture, execute and result load
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output deq_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.exec    = (state_q == S_EXEC);
	// result register frees up when empty or being taken this cycle
	assign cmd.load    = (state_q == S_LOAD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/deq_datapath.sv
// datapath: ring storage, front and back pointers, occupancy and result register
`default_nettype none

module deq_datapath
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire deq_cmd_t             cmd,
	input  wire logic [1:0]           in_mode,
	input  wire logic [VALUE_W-1:0]   in_value,
	output logic [VALUE_W-1:0]        out_value,
	output logic [1:0]                out_status,
	output logic [CW-1:0]             out_count,
	output logic                      out_empty
);

	localparam int unsigned SW       = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam logic [AW-1:0] LAST   = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_N = CW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	mode_t           mode_q;
	logic [SW-1:0]   word_q;
	logic [AW-1:0]   front_q;
	logic [AW-1:0]   back_q;
	logic [CW-1:0]   occ_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic            hit_q;
	status_t         st_q;

	logic [VALUE_W-1:0] value_out_q;
	status_t            status_out_q;
	logic [CW-1:0]      count_out_q;
	logic               empty_out_q;

	logic          full;
	logic          none;
	logic [AW-1:0] front_next;
	logic [AW-1:0] front_prev;
	logic [AW-1:0] back_next;
	logic [AW-1:0] back_prev;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign full       = (occ_q == FULL_N);
	assign none       = (occ_q == '0);
	assign front_next = (front_q == LAST) ? '0 : front_q + AW'(1);
	assign front_prev = (front_q == '0) ? LAST : front_q - AW'(1);
	assign back_next  = (back_q == LAST) ? '0 : back_q + AW'(1);
	assign back_prev  = (back_q == '0) ? LAST : back_q - AW'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = back_q;
		rd_en   = 1'b0;
		rd_addr = front_q;
		if (cmd.exec) begin
			case (mode_q)
				MODE_PUSH_FRONT: begin
					wr_en   = !full;
					wr_addr = front_prev;
				end
				MODE_PUSH_BACK: begin
					wr_en   = !full;
					wr_addr = back_q;
				end
				MODE_POP_FRONT: begin
					rd_en   = !none;
					rd_addr = front_q;
				end
				MODE_POP_BACK: begin
					rd_en   = !none;
					rd_addr = back_prev;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= DATA_WIDTH'(word_q);
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			occ_q   <= '0;
		end else if (cmd.exec) begin
			case (mode_q)
				MODE_PUSH_FRONT: begin
					if (!full) begin
						front_q <= front_prev;
						occ_q   <= occ_q + CW'(1);
					end
				end
				MODE_PUSH_BACK: begin
					if (!full) begin
						back_q <= back_next;
						occ_q  <= occ_q + CW'(1);
					end
				end
				MODE_POP_FRONT: begin
					if (!none) begin
						front_q <= front_next;
						occ_q   <= occ_q - CW'(1);
					end
				end
				MODE_POP_BACK: begin
					if (!none) begin
						back_q <= back_prev;
						occ_q  <= occ_q - CW'(1);
					end
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	// item capture, outcome and result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(in_mode);
			word_q <= in_value[SW-1:0];
		end
		if (cmd.exec) begin
			hit_q <= 1'b0;
			st_q  <= ST_DONE;
			case (mode_q)
				MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
					if (full) begin
						st_q <= ST_FULL;
					end
				end
				MODE_POP_FRONT, MODE_POP_BACK: begin
					if (none) begin
						st_q <= ST_EMPTY;
					end else begin
						hit_q <= 1'b1;
					end
				end
				default: begin
					st_q <= ST_DONE;
				end
			endcase
		end
		if (cmd.load) begin
			value_out_q  <= hit_q ? VALUE_W'(rdata_q[SW-1:0]) : '0;
			status_out_q <= st_q;
			count_out_q  <= occ_q;
			empty_out_q  <= none;
		end
	end

	assign out_value  = value_out_q;
	assign out_status = status_out_q;
	assign out_count  = count_out_q;
	assign out_empty  = empty_out_q;

endmodule

`default_nettype wire

### src/double_ended_queue.sv
// top level of the double-ended queue: controller plus datapath
//
// channel   dir  tdata                                  tuser
// s_axis    in   value_in[31:0]                         mode[1:0]
// m_axis    out  value_out[31:0], count, is_empty, pad  status[1:0]
//
// each item goes through three steps: capture, execute (one ring write or read), load result
// the ring memory sees at most one write or one read per item and one operation runs at a time
// a new item is taken while the previous result still waits on m_axis
// reset clears pointers and occupancy; ring contents are not cleared
// a stalled result holds the block in its load step until m_axis_tready
`default_nettype none

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [31:0]      s_axis_tdata,   // value_in[31:0]
	input  wire logic [1:0]       s_axis_tuser,   // mode[1:0]
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// value_out, count, is_empty, zero pad
	output logic [((VALUE_W + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic [1:0]            m_axis_tuser    // status[1:0]
);

	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned OTW = ((VALUE_W + CW + 1 + 7) / 8) * 8;

	deq_cmd_t           cmd;
	logic [VALUE_W-1:0] value_out;
	logic [CW-1:0]      count;
	logic               is_empty;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	deq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_mode    (s_axis_tuser),
		.in_value   (s_axis_tdata),
		.out_value  (value_out),
		.out_status (m_axis_tuser),
		.out_count  (count),
		.out_empty  (is_empty)
	);

	assign m_axis_tdata = OTW'({is_empty, count, value_out});

endmodule

`default_nettype wire
